[sv/amg_pkg.sv]
// Shared types, constants and helpers for the adjacency matrix graph store.
// No dependencies; used by every module of the block.
package amg_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int ROW_W            = 32;
    localparam int CNT_W            = 6;
    localparam int SRC_W            = 6;
    localparam int IDX_W            = 5;
    localparam int CMD_W            = 3;
    localparam int ST_W             = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 3'd0,
        CMD_LOAD_ROW = 3'd1,
        CMD_INS_VTX  = 3'd2,
        CMD_INS_EDGE = 3'd3,
        CMD_DEL_VTX  = 3'd4,
        CMD_DEL_EDGE = 3'd5,
        CMD_PRINT    = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_BAD_PAIR     = 3'd2,
        ST_VTX_MISSING  = 3'd3,
        ST_EDGE_MISSING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE,
        S_DELV,
        S_DDRAIN,
        S_PRINT,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        ROP_MASK,
        ROP_SET,
        ROP_CLR,
        ROP_COMPACT
    } t_rowop;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SRC_W-1:0] src;
        logic [SRC_W-1:0] dest;
        logic [ROW_W-1:0] row_bits;
        logic [CNT_W-1:0] vertex_count;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count_now;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_out;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
        logic clr_one;
    } t_mem_ctl;

    function automatic logic [ROW_W-1:0] live_mask(input logic [CNT_W-1:0] count);
        logic [ROW_W:0] wide;
        wide = ((ROW_W+1)'(1) << count) - (ROW_W+1)'(1);
        if (count >= CNT_W'(ROW_W)) begin
            return '1;
        end
        return wide[ROW_W-1:0];
    endfunction

endpackage

[sv/amg_rowalu.sv]
// Shared row unit: load masking, single-bit set/clear and column compaction.
// Depends on amg_pkg.
module amg_rowalu #(
    parameter int AW = 5
) (
    input  amg_pkg::t_rowop                 i_op,
    input  logic [amg_pkg::ROW_W-1:0]       i_row,
    input  logic [AW-1:0]                   i_pos,
    input  logic [amg_pkg::CNT_W-1:0]       i_count,
    output logic [amg_pkg::ROW_W-1:0]       o_row,
    output logic                            o_hit
);

    logic [amg_pkg::ROW_W-1:0] w_bit;
    logic [AW:0]               w_pos_p1;

    assign w_bit    = amg_pkg::ROW_W'(1) << i_pos;
    assign w_pos_p1 = {1'b0, i_pos} + (AW+1)'(1);
    assign o_hit    = |(i_row & w_bit);

    always_comb begin
        case (i_op)
            amg_pkg::ROP_MASK:    o_row = i_row & amg_pkg::live_mask(i_count);
            amg_pkg::ROP_SET:     o_row = i_row | w_bit;
            amg_pkg::ROP_CLR:     o_row = i_row & ~w_bit;
            amg_pkg::ROP_COMPACT: o_row = (i_row & (w_bit - amg_pkg::ROW_W'(1)))
                                        | ((i_row >> w_pos_p1) << i_pos);
            default:              o_row = i_row;
        endcase
    end

endmodule

[sv/amg_mem.sv]
// Row store of the matrix with per-row valid bits and a registered read port.
// Depends on amg_pkg.
module amg_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  amg_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]               i_raddr,
    input  logic [AW-1:0]               i_waddr,
    input  logic [amg_pkg::ROW_W-1:0]   i_wdata,
    input  logic [AW-1:0]               i_cidx,
    output logic [amg_pkg::ROW_W-1:0]   o_rd_row
);

    logic [amg_pkg::ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]          r_vld;
    logic [amg_pkg::ROW_W-1:0] r_rdata;
    logic                      r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    // invalid rows read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr_all) begin
            r_vld <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.clr_one) begin
                r_vld[i_cidx] <= 1'b0;
            end
        end
    end

    assign o_rd_row = r_rvld ? r_rdata : '0;

endmodule

[sv/adjacency_matrix_graph_store.sv]
// Adjacency matrix graph store: directed graph of up to min(MAX_VERTICES, 32)
// vertices held as one 32-bit row per vertex in a row memory with one read and
// one write port and per-row valid bits, so reset and start clear the matrix at
// once (no clearing pass). One command is taken at a time; the input stalls
// until its last result is registered. Start, load row, insert vertex and
// unknown codes go from execute straight to the result; insert/delete edge
// read, then modify-write one row. Delete vertex: the shared row unit compacts
// one row per cycle as the memory streams rows past it. Print gives one row per
// cycle from the memory read port while the output is not stalled.
// Depends on amg_pkg, amg_mem and amg_rowalu.
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  amg_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output amg_pkg::t_out_item  o_item
);

    localparam int CAP = (MAX_VERTICES < amg_pkg::ROW_W) ? MAX_VERTICES : amg_pkg::ROW_W;
    localparam int AW  = $clog2(CAP);
    localparam logic [amg_pkg::CNT_W-1:0] CAP_C = amg_pkg::CNT_W'(CAP);

    amg_pkg::t_state            r_state, n_state;
    amg_pkg::t_in_item          r_in;
    logic [amg_pkg::CNT_W-1:0]  r_count, n_count;
    logic [amg_pkg::ST_W-1:0]   r_status, n_status;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_k, n_k;
    logic [AW-1:0]              r_widx, n_widx;
    logic                       r_wpend, n_wpend;
    logic                       r_ovld, n_ovld;
    amg_pkg::t_out_item         r_out, n_out;

    amg_pkg::t_mem_ctl          w_mc;
    logic [AW-1:0]              w_raddr, w_waddr, w_cidx;
    logic [amg_pkg::ROW_W-1:0]  w_rd_row, w_alu_a, w_alu_y;
    amg_pkg::t_rowop            w_op;
    logic [AW-1:0]              w_pos;
    logic                       w_hit;

    logic                       w_ofree;
    logic                       w_src_ok, w_dst_ok;
    logic [AW-1:0]              w_s_idx, w_d_idx, w_last, w_cnt_idx;

    assign w_ofree   = !r_ovld || !i_stall;
    assign w_src_ok  = (r_in.src != '0) && (r_in.src <= r_count);
    assign w_dst_ok  = (r_in.dest != '0) && (r_in.dest <= r_count);
    assign w_s_idx   = AW'(r_in.src - amg_pkg::SRC_W'(1));
    assign w_d_idx   = AW'(r_in.dest - amg_pkg::SRC_W'(1));
    assign w_last    = AW'(r_count - amg_pkg::CNT_W'(1));
    assign w_cnt_idx = AW'(r_count);

    assign o_stall = (r_state != amg_pkg::S_IDLE);
    assign o_valid = r_ovld;
    assign o_item  = r_out;

    amg_mem #(
        .DEPTH (CAP),
        .AW    (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mc),
        .i_raddr  (w_raddr),
        .i_waddr  (w_waddr),
        .i_wdata  (w_alu_y),
        .i_cidx   (w_cidx),
        .o_rd_row (w_rd_row)
    );

    amg_rowalu #(
        .AW (AW)
    ) u_alu (
        .i_op    (w_op),
        .i_row   (w_alu_a),
        .i_pos   (w_pos),
        .i_count (r_count),
        .o_row   (w_alu_y),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            amg_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = amg_pkg::S_EXEC;
                end
            end
            amg_pkg::S_EXEC: begin
                case (r_in.command)
                    amg_pkg::CMD_INS_EDGE, amg_pkg::CMD_DEL_EDGE: begin
                        n_state = (w_src_ok && w_dst_ok) ? amg_pkg::S_EDGE : amg_pkg::S_RESP;
                    end
                    amg_pkg::CMD_DEL_VTX: begin
                        n_state = w_src_ok ? amg_pkg::S_DELV : amg_pkg::S_RESP;
                    end
                    amg_pkg::CMD_PRINT: begin
                        n_state = (r_count != '0) ? amg_pkg::S_PRINT : amg_pkg::S_RESP;
                    end
                    default: n_state = amg_pkg::S_RESP;
                endcase
            end
            amg_pkg::S_EDGE:   n_state = amg_pkg::S_RESP;
            amg_pkg::S_DELV: begin
                if (r_idx == w_last) begin
                    n_state = amg_pkg::S_DDRAIN;
                end
            end
            amg_pkg::S_DDRAIN: n_state = amg_pkg::S_RESP;
            amg_pkg::S_PRINT: begin
                if (w_ofree && (r_idx == w_last)) begin
                    n_state = amg_pkg::S_IDLE;
                end
            end
            amg_pkg::S_RESP: begin
                if (w_ofree) begin
                    n_state = amg_pkg::S_IDLE;
                end
            end
            default: n_state = amg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        n_idx    = r_idx;
        n_k      = r_k;
        n_wpend  = 1'b0;
        n_widx   = r_widx;
        n_ovld   = r_ovld && i_stall;
        n_out    = r_out;
        w_mc     = '0;
        w_raddr  = r_idx;
        w_waddr  = r_widx;
        w_cidx   = w_last;
        w_op     = amg_pkg::ROP_COMPACT;
        w_alu_a  = w_rd_row;
        w_pos    = r_k;

        // compacted row from the previous delete-vertex read
        if (r_wpend) begin
            w_mc.wr_en = 1'b1;
        end

        case (r_state)
            amg_pkg::S_IDLE: begin
                n_status = amg_pkg::ST_OK;
            end
            amg_pkg::S_EXEC: begin
                case (r_in.command)
                    amg_pkg::CMD_START: begin
                        w_mc.clr_all = 1'b1;
                        if (r_in.vertex_count > CAP_C) begin
                            n_count  = CAP_C;
                            n_status = amg_pkg::ST_FULL;
                        end else begin
                            n_count = r_in.vertex_count;
                        end
                    end
                    amg_pkg::CMD_LOAD_ROW: begin
                        if (w_src_ok) begin
                            w_mc.wr_en = 1'b1;
                            w_waddr    = w_s_idx;
                            w_op       = amg_pkg::ROP_MASK;
                            w_alu_a    = r_in.row_bits;
                        end else begin
                            n_status = amg_pkg::ST_VTX_MISSING;
                        end
                    end
                    amg_pkg::CMD_INS_VTX: begin
                        if (r_count < CAP_C) begin
                            w_mc.clr_one = 1'b1;
                            w_cidx       = w_cnt_idx;
                            n_count      = r_count + amg_pkg::CNT_W'(1);
                        end else begin
                            n_status = amg_pkg::ST_FULL;
                        end
                    end
                    amg_pkg::CMD_INS_EDGE, amg_pkg::CMD_DEL_EDGE: begin
                        if (w_src_ok && w_dst_ok) begin
                            w_mc.rd_en = 1'b1;
                            w_raddr    = w_s_idx;
                        end else begin
                            n_status = amg_pkg::ST_BAD_PAIR;
                        end
                    end
                    amg_pkg::CMD_DEL_VTX: begin
                        if (w_src_ok) begin
                            n_idx = '0;
                            n_k   = w_s_idx;
                        end else begin
                            n_status = amg_pkg::ST_VTX_MISSING;
                        end
                    end
                    amg_pkg::CMD_PRINT: begin
                        if (r_count != '0) begin
                            w_mc.rd_en = 1'b1;
                            w_raddr    = '0;
                            n_idx      = '0;
                        end
                    end
                    default: ;
                endcase
            end
            amg_pkg::S_EDGE: begin
                w_pos   = w_d_idx;
                w_alu_a = w_rd_row;
                w_waddr = w_s_idx;
                if (r_in.command == amg_pkg::CMD_INS_EDGE) begin
                    w_op       = amg_pkg::ROP_SET;
                    w_mc.wr_en = 1'b1;
                end else if (w_hit) begin
                    w_op       = amg_pkg::ROP_CLR;
                    w_mc.wr_en = 1'b1;
                end else begin
                    n_status = amg_pkg::ST_EDGE_MISSING;
                end
            end
            amg_pkg::S_DELV: begin
                if (r_idx == w_last) begin
                    w_mc.clr_one = 1'b1;
                    w_cidx       = w_last;
                end else begin
                    w_mc.rd_en = 1'b1;
                    w_raddr    = (r_idx >= r_k) ? (r_idx + AW'(1)) : r_idx;
                    n_wpend    = 1'b1;
                    n_widx     = r_idx;
                    n_idx      = r_idx + AW'(1);
                end
            end
            amg_pkg::S_DDRAIN: begin
                n_count = r_count - amg_pkg::CNT_W'(1);
            end
            amg_pkg::S_PRINT: begin
                if (w_ofree) begin
                    n_ovld          = 1'b1;
                    n_out.status    = amg_pkg::ST_OK;
                    n_out.count_now = r_count;
                    n_out.row_index = amg_pkg::IDX_W'(r_idx);
                    n_out.row_out   = w_rd_row;
                    n_out.last      = (r_idx == w_last);
                    if (r_idx != w_last) begin
                        w_mc.rd_en = 1'b1;
                        w_raddr    = r_idx + AW'(1);
                        n_idx      = r_idx + AW'(1);
                    end
                end
            end
            amg_pkg::S_RESP: begin
                if (w_ofree) begin
                    n_ovld          = 1'b1;
                    n_out.status    = r_status;
                    n_out.count_now = r_count;
                    n_out.row_index = '0;
                    n_out.row_out   = '0;
                    n_out.last      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amg_pkg::S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == amg_pkg::S_IDLE && i_valid) begin
            r_in <= i_item;
        end
        r_status <= n_status;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_widx   <= n_widx;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("vertex count above capacity");

    a_wpend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_state == amg_pkg::S_DELV || r_state == amg_pkg::S_DDRAIN))
        else $error("compaction write outside delete vertex");

    a_delv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amg_pkg::S_DDRAIN) |=> (r_count == $past(r_count) - amg_pkg::CNT_W'(1)))
        else $error("delete vertex did not drop the count by one");

    a_print_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_out.last) |->
            (({1'b0, r_out.row_index} + amg_pkg::CNT_W'(1)) < r_out.count_now))
        else $error("non-final print row beyond vertex count");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for adjacency_matrix_graph_store: directed and random graph commands.
// Needs amg_pkg and the block's RTL; a mirror class predicts every result and checks it.
module testbench;

    localparam logic [amg_pkg::CMD_W-1:0] CMD_UNUSED   = 3'd7;
    localparam int                        CYCLE_LIMIT  = 400000;
    localparam int                        DRAIN_WAIT   = 40;
    localparam int                        RANDOM_ITEMS = 75;

    class graph_mirror;
        logic [amg_pkg::ROW_W-1:0] rows [32];
        logic [amg_pkg::CNT_W-1:0] total;
        amg_pkg::t_out_item        due [$];
        int                        mismatches;
        int                        capacity;

        function new();
            capacity = (amg_pkg::MAX_VERTICES_DEF < amg_pkg::ROW_W) ?
                       amg_pkg::MAX_VERTICES_DEF : amg_pkg::ROW_W;
            foreach (rows[i]) rows[i] = '0;
            total = '0;
            mismatches = 0;
        endfunction

        function bit live(logic [amg_pkg::SRC_W-1:0] v);
            return v >= 1 && v <= total;
        endfunction

        function void queue_result(logic [amg_pkg::ST_W-1:0] st, int idx,
                                   logic [amg_pkg::ROW_W-1:0] bits, bit fin);
            amg_pkg::t_out_item r;
            r.status    = st;
            r.count_now = total;
            r.row_index = amg_pkg::IDX_W'(idx);
            r.row_out   = bits;
            r.last      = fin;
            due.push_back(r);
        endfunction

        // Note one accepted transfer and queue the results it causes.
        function void apply_command(amg_pkg::t_in_item it);
            logic [amg_pkg::ST_W-1:0]  st;
            logic [amg_pkg::ROW_W-1:0] low;
            logic [amg_pkg::ROW_W-1:0] row;
            int                        k;
            int                        s;
            int                        d;
            st = amg_pkg::ST_OK;
            s = int'(it.src) - 1;
            d = int'(it.dest) - 1;
            case (it.command)
                amg_pkg::CMD_START: begin
                    foreach (rows[i]) rows[i] = '0;
                    if (it.vertex_count > capacity) begin
                        total = amg_pkg::CNT_W'(capacity);
                        st = amg_pkg::ST_FULL;
                    end else begin
                        total = it.vertex_count;
                    end
                end
                amg_pkg::CMD_LOAD_ROW: begin
                    if (live(it.src)) begin
                        row = (total >= amg_pkg::ROW_W) ? '1 : ((32'h1 << total) - 32'h1);
                        rows[s] = it.row_bits & row;
                    end else begin
                        st = amg_pkg::ST_VTX_MISSING;
                    end
                end
                amg_pkg::CMD_INS_VTX: begin
                    if (total < capacity) begin
                        k = int'(total);
                        rows[k] = '0;
                        total = total + 1'b1;
                        for (int i = 0; i < total; i++) rows[i][k] = 1'b0;
                    end else begin
                        st = amg_pkg::ST_FULL;
                    end
                end
                amg_pkg::CMD_INS_EDGE: begin
                    if (live(it.src) && live(it.dest)) rows[s][d] = 1'b1;
                    else st = amg_pkg::ST_BAD_PAIR;
                end
                amg_pkg::CMD_DEL_VTX: begin
                    if (live(it.src)) begin
                        k = s;
                        for (int i = k; i + 1 < total; i++) rows[i] = rows[i + 1];
                        rows[int'(total) - 1] = '0;
                        total = total - 1'b1;
                        low = (32'h1 << k) - 32'h1;
                        for (int i = 0; i < total; i++) begin
                            row = rows[i];
                            rows[i] = (row & low) | ((row >> (k + 1)) << k);
                        end
                    end else begin
                        st = amg_pkg::ST_VTX_MISSING;
                    end
                end
                amg_pkg::CMD_DEL_EDGE: begin
                    if (!(live(it.src) && live(it.dest))) st = amg_pkg::ST_BAD_PAIR;
                    else if (rows[s][d]) rows[s][d] = 1'b0;
                    else st = amg_pkg::ST_EDGE_MISSING;
                end
                amg_pkg::CMD_PRINT: begin
                    if (total == 0) begin
                        queue_result(amg_pkg::ST_OK, 0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < total; i++) begin
                            queue_result(amg_pkg::ST_OK, i, rows[i], i + 1 == total);
                        end
                    end
                    return;
                end
                default: ;
            endcase
            queue_result(st, 0, '0, 1'b1);
        endfunction

        function void compare_response(amg_pkg::t_out_item got);
            amg_pkg::t_out_item want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: st=%0d cnt=%0d idx=%0d row=%h last=%0d",
                             got.status, got.count_now, got.row_index, got.row_out, got.last);
                end
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status || got.count_now !== want.count_now ||
                got.row_index !== want.row_index || got.row_out !== want.row_out ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected st=%0d cnt=%0d idx=%0d row=%h last=%0d",
                             want.status, want.count_now, want.row_index, want.row_out,
                             want.last);
                    $display("          got      st=%0d cnt=%0d idx=%0d row=%h last=%0d",
                             got.status, got.count_now, got.row_index, got.row_out, got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    amg_pkg::t_in_item  i_item  = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    amg_pkg::t_out_item o_item;

    graph_mirror mirror = new();
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;

    adjacency_matrix_graph_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** adjacency_matrix_graph_store: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            mirror.compare_response(o_item);
        end
    end

    task automatic issue(logic [amg_pkg::CMD_W-1:0] cmd, logic [amg_pkg::SRC_W-1:0] s,
                         logic [amg_pkg::SRC_W-1:0] d, logic [amg_pkg::ROW_W-1:0] bits,
                         logic [amg_pkg::CNT_W-1:0] n);
        amg_pkg::t_in_item it;
        it.command      = cmd;
        it.src          = s;
        it.dest         = d;
        it.row_bits     = bits;
        it.vertex_count = n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.apply_command(it);
    endtask

    function automatic logic [amg_pkg::SRC_W-1:0] pick_vertex();
        if (mirror.total != 0 && $urandom_range(99) < 85) begin
            return amg_pkg::SRC_W'($urandom_range(mirror.total, 1));
        end
        return amg_pkg::SRC_W'($urandom_range(63));
    endfunction

    task automatic random_command();
        int                        r;
        int                        tries;
        logic [amg_pkg::CMD_W-1:0] c;
        logic [amg_pkg::SRC_W-1:0] s;
        logic [amg_pkg::SRC_W-1:0] d;
        logic [amg_pkg::CNT_W-1:0] n;
        logic [amg_pkg::ROW_W-1:0] bits;
        r = $urandom_range(99);
        s = pick_vertex();
        d = pick_vertex();
        n = amg_pkg::CNT_W'($urandom_range(63));
        bits = ($urandom_range(1)) ? $urandom() : ($urandom() & $urandom());
        if (r < 6) begin
            c = amg_pkg::CMD_START;
            tries = $urandom_range(99);
            if (tries < 70) n = amg_pkg::CNT_W'($urandom_range(8, 1));
            else if (tries < 80) n = amg_pkg::CNT_W'(amg_pkg::ROW_W);
            else if (tries < 90) n = amg_pkg::CNT_W'($urandom_range(31, 9));
        end else if (r < 20) begin
            c = amg_pkg::CMD_LOAD_ROW;
        end else if (r < 32) begin
            c = amg_pkg::CMD_INS_VTX;
        end else if (r < 52) begin
            c = amg_pkg::CMD_INS_EDGE;
        end else if (r < 62) begin
            c = amg_pkg::CMD_DEL_VTX;
        end else if (r < 82) begin
            c = amg_pkg::CMD_DEL_EDGE;
            if (mirror.live(s) && mirror.rows[s - 1] != 0 && $urandom_range(1)) begin
                tries = 0;
                while (!(mirror.live(d) && mirror.rows[s - 1][d - 1]) && tries < 64) begin
                    d = amg_pkg::SRC_W'($urandom_range(mirror.total, 1));
                    tries++;
                end
            end
        end else if (r < 96) begin
            c = amg_pkg::CMD_PRINT;
        end else begin
            c = CMD_UNUSED;
        end
        issue(c, s, d, bits, n);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(amg_pkg::CMD_START,    6'd0,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_PRINT,    6'd0,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_INS_EDGE, 6'd1,  6'd1,  32'h0, 6'd0);
        issue(amg_pkg::CMD_START,    6'd0,  6'd0,  '1,    6'd63);
        issue(amg_pkg::CMD_INS_VTX,  6'd0,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_LOAD_ROW, 6'd32, 6'd0,  '1,    6'd0);
        issue(amg_pkg::CMD_LOAD_ROW, 6'd0,  6'd0,  '1,    6'd0);
        issue(amg_pkg::CMD_LOAD_ROW, 6'd33, 6'd0,  '1,    6'd0);
        issue(amg_pkg::CMD_INS_EDGE, 6'd1,  6'd32, 32'h0, 6'd0);
        issue(amg_pkg::CMD_INS_EDGE, 6'd32, 6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_INS_EDGE, 6'd63, 6'd1,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_EDGE, 6'd2,  6'd2,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_EDGE, 6'd32, 6'd1,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_VTX,  6'd0,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_VTX,  6'd40, 6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_VTX,  6'd1,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_VTX,  6'd31, 6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_PRINT,    6'd0,  6'd0,  32'h0, 6'd0);
        issue(CMD_UNUSED,            6'd63, 6'd63, '1,    6'd63);
        issue(amg_pkg::CMD_START,    6'd0,  6'd0,  32'h0, 6'd3);
        issue(amg_pkg::CMD_LOAD_ROW, 6'd2,  6'd0,  '1,    6'd0);
        issue(amg_pkg::CMD_INS_VTX,  6'd0,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_INS_EDGE, 6'd4,  6'd4,  32'h0, 6'd0);
        issue(amg_pkg::CMD_DEL_VTX,  6'd2,  6'd0,  32'h0, 6'd0);
        issue(amg_pkg::CMD_PRINT,    6'd0,  6'd0,  32'h0, 6'd0);

        // receiver-heavy stalling, then sender-heavy idling, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 80 : 0;
            recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 22 : 0;
            repeat (RANDOM_ITEMS) random_command();
        end
        i_valid <= 1'b0;

        while (mirror.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.due.size() == 0) begin
            $display("** adjacency_matrix_graph_store: PASSED **");
        end else begin
            $display("** adjacency_matrix_graph_store: FAILED **");
        end
        $finish;
    end
endmodule
